FILE: design/ilbm_bitplane_pixel_decoder_macros.svh
// Assertion macros for the ILBM bitplane pixel decoder.
// Expects i_clk and i_rst_n in the scope of the including module.
`ifndef ILBM_BITPLANE_PIXEL_DECODER_MACROS_SVH
`define ILBM_BITPLANE_PIXEL_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define IBPD_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ibpd: same-cycle check failed");
`define IBPD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ibpd: next-cycle check failed");
`else
`define IBPD_ASSERT_IMPL(name, ante, cons)
`define IBPD_ASSERT_NEXT(name, ante, cons)
`endif
`endif

FILE: design/ibpd_pkg.sv
// Package for the ILBM bitplane pixel decoder: defaults, codes and helpers.
// No dependencies.
`default_nettype none

package ibpd_pkg;

    localparam int MAX_WIDTH_DEF     = 1024;
    localparam int MAX_PLANES_DEF    = 24;
    localparam int PALETTE_DEPTH_DEF = 256;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int CODE_W     = 24;
    localparam int COLOR_W    = 8;
    localparam int COLUMN_W   = 10;
    localparam int RGB_PLANES = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_PLANE_COUNT   = 2'd1,
        CFG_HAM_MODE      = 2'd2,
        CFG_PALETTE_COUNT = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_INDEXED = 2'd0,
        ST_RGB     = 2'd1,
        ST_BAD_HAM = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    typedef enum logic {
        CMD_PALETTE = 1'b0,
        CMD_PLANE   = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        HAM_SET   = 2'd0,
        HAM_BLUE  = 2'd1,
        HAM_RED   = 2'd2,
        HAM_GREEN = 2'd3
    } t_ham_op;

    function automatic logic [COLOR_W-1:0] widen_nibble(input logic [3:0] nib);
        return {nib, nib};
    endfunction

endpackage

`default_nettype wire

FILE: design/ibpd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module ibpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/ilbm_bitplane_pixel_decoder.sv
// Top level of the ILBM bitplane pixel decoder: row store, pixel shifter, HAM/RGB/index decode.
// Depends on ibpd_pkg, ibpd_ram and ilbm_bitplane_pixel_decoder_macros.svh.
//
//  channel | direction | handshake                    | carries
//  in      | sink      | i_in_valid / o_in_ready      | palette entry or one plane byte
//  out     | source    | o_out_valid / i_out_ready    | one decoded pixel
//  cfg     | sink      | i_cfg_valid / o_cfg_ready    | register index and data
//
// Bytes of earlier planes follow back to back, each doing a read-modify-write of one
// row-store word (the earlier planes of one byte column): read on accept, written in stage 1.
// A last-plane byte releases up to eight pixels through the pixel shifter, which feeds the
// single palette read port; each pixel then passes the decode stage and the output register.
// A palette write waits until no plane byte is in flight. Reset needs no clearing pass.
// Results wait in the output register; the shifter stalls behind it.
`default_nettype none
`include "ilbm_bitplane_pixel_decoder_macros.svh"

module ilbm_bitplane_pixel_decoder
    import ibpd_pkg::*;
#(
    parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
    parameter int MAX_PLANES    = MAX_PLANES_DEF,
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,

    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_cmd,
    input  wire logic [7:0]            i_entry_index,
    input  wire logic [COLOR_W-1:0]    i_entry_red,
    input  wire logic [COLOR_W-1:0]    i_entry_green,
    input  wire logic [COLOR_W-1:0]    i_entry_blue,
    input  wire logic [7:0]            i_plane_byte,

    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic      [1:0]            o_status,
    output logic      [CODE_W-1:0]     o_pixel_code,
    output logic      [COLOR_W-1:0]    o_red,
    output logic      [COLOR_W-1:0]    o_green,
    output logic      [COLOR_W-1:0]    o_blue,
    output logic      [COLUMN_W-1:0]   o_column,
    output logic                       o_row_end
);

    localparam int ROW_LEN_MAX = ((MAX_WIDTH + 15) / 16) * 2;
    localparam int BP_W   = $clog2(ROW_LEN_MAX);
    localparam int PP_W   = $clog2(MAX_PLANES);
    localparam int NP_W   = $clog2(MAX_PLANES + 1);
    localparam int WD_W   = $clog2(MAX_WIDTH + 1);
    localparam int RB_W   = $clog2(ROW_LEN_MAX + 1);
    localparam int COL_W  = BP_W + 3;
    localparam int LANES  = MAX_PLANES - 1;
    localparam int ROW_DW = LANES * 8;
    localparam int PAL_AW = $clog2(PALETTE_DEPTH);
    localparam int PC_W   = $clog2(PALETTE_DEPTH + 1);
    localparam int PAL_DW = 3 * COLOR_W;

    // configuration
    logic [WD_W-1:0] r_width,  n_width;
    logic [NP_W-1:0] r_planes, n_planes;
    logic            r_ham,    n_ham;
    logic [PC_W-1:0] r_pal,    n_pal;
    logic            w_cfg_acc;
    logic            w_cfg_pos_clr;
    logic [WD_W:0]   w_w_sum;
    logic [RB_W-1:0] w_row_len;

    // position
    logic [PP_W-1:0] r_plane_pos, n_plane_pos;
    logic [BP_W-1:0] r_byte_pos,  n_byte_pos;
    logic            w_byte_wrap;
    logic            w_plane_last;

    // handshake
    logic w_in_acc;
    logic w_plane_acc;
    logic w_pal_acc;
    logic w_pipe_empty;

    // stage 1: row-store read data
    logic            r_s1_valid;
    logic            r_s1_last;
    logic [PP_W-1:0] r_s1_plane;
    logic [BP_W-1:0] r_s1_byte;
    logic [7:0]      r_s1_data;
    logic            w_s1_adv;
    logic            w_s1_free;
    logic            w_s1_emit;
    logic [COL_W-1:0] w_s1_base;
    logic [MAX_PLANES*8-1:0] w_s1_word;
    logic [MAX_PLANES-1:0]   w_s1_codes [8];

    logic              w_row_we;
    logic [ROW_DW-1:0] w_row_wdata;
    logic [ROW_DW-1:0] w_row_rdata;

    // pixel shifter
    logic                  r_pb_valid;
    logic [MAX_PLANES-1:0] r_pb_codes [8];
    logic [COL_W-1:0]      r_pb_col;
    logic                  w_pb_row_end;
    logic                  w_pb_last;
    logic                  w_pb_free;
    logic                  w_p_adv;

    // decode stage
    logic                  r_d_valid;
    logic [MAX_PLANES-1:0] r_d_code;
    logic [COL_W-1:0]      r_d_col;
    logic                  r_d_row_end;
    logic                  w_d_adv;
    logic                  w_d_free;
    logic [CODE_W-1:0]     w_code;
    logic [PAL_DW-1:0]     w_pal_rdata;
    logic                  w_pal_we;
    t_status               w_status;
    logic [COLOR_W-1:0]    w_red, w_green, w_blue;

    // held colour
    logic [COLOR_W-1:0] r_held_red,   n_held_red;
    logic [COLOR_W-1:0] r_held_green, n_held_green;
    logic [COLOR_W-1:0] r_held_blue,  n_held_blue;

    // output register
    logic                r_out_valid;
    t_status             r_out_status;
    logic [CODE_W-1:0]   r_out_code;
    logic [COLOR_W-1:0]  r_out_red, r_out_green, r_out_blue;
    logic [COLUMN_W-1:0] r_out_column;
    logic                r_out_row_end;

    //--------------------------------------------------------------------------
    // configuration
    //--------------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_width       = r_width;
        n_planes      = r_planes;
        n_ham         = r_ham;
        n_pal         = r_pal;
        w_cfg_pos_clr = 1'b0;
        if (w_cfg_acc) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH: begin
                    if (i_cfg_data == '0) begin
                        n_width = WD_W'(1);
                    end else if (32'(i_cfg_data) > MAX_WIDTH) begin
                        n_width = WD_W'(MAX_WIDTH);
                    end else begin
                        n_width = WD_W'(i_cfg_data);
                    end
                    w_cfg_pos_clr = 1'b1;
                end
                CFG_PLANE_COUNT: begin
                    if (i_cfg_data[4:0] == '0) begin
                        n_planes = NP_W'(1);
                    end else if (32'(i_cfg_data[4:0]) > MAX_PLANES) begin
                        n_planes = NP_W'(MAX_PLANES);
                    end else begin
                        n_planes = NP_W'(i_cfg_data[4:0]);
                    end
                    w_cfg_pos_clr = 1'b1;
                end
                CFG_HAM_MODE: begin
                    n_ham = i_cfg_data[0];
                end
                CFG_PALETTE_COUNT: begin
                    if (32'(i_cfg_data[8:0]) > PALETTE_DEPTH) begin
                        n_pal = PC_W'(PALETTE_DEPTH);
                    end else begin
                        n_pal = PC_W'(i_cfg_data[8:0]);
                    end
                end
            endcase
        end
    end

    assign w_w_sum   = {1'b0, r_width} + (WD_W + 1)'(15);
    assign w_row_len = RB_W'({w_w_sum[WD_W:4], 1'b0});

    //--------------------------------------------------------------------------
    // input handshake and row position
    //--------------------------------------------------------------------------
    assign w_pipe_empty = !r_s1_valid && !r_pb_valid && !r_d_valid;
    assign o_in_ready   = (i_cmd == CMD_PLANE) ? w_s1_free : w_pipe_empty;
    assign w_in_acc     = i_in_valid && o_in_ready;
    assign w_plane_acc  = w_in_acc && (i_cmd == CMD_PLANE);
    assign w_pal_acc    = w_in_acc && (i_cmd == CMD_PALETTE);

    assign w_byte_wrap  = (32'(r_byte_pos) + 32'd1) >= 32'(w_row_len);
    assign w_plane_last = (32'(r_plane_pos) + 32'd1) >= 32'(r_planes);

    always_comb begin
        n_plane_pos = r_plane_pos;
        n_byte_pos  = r_byte_pos;
        if (w_cfg_pos_clr) begin
            n_plane_pos = '0;
            n_byte_pos  = '0;
        end else if (w_plane_acc) begin
            if (w_byte_wrap) begin
                n_byte_pos  = '0;
                n_plane_pos = w_plane_last ? '0 : r_plane_pos + PP_W'(1);
            end else begin
                n_byte_pos = r_byte_pos + BP_W'(1);
            end
        end
    end

    //--------------------------------------------------------------------------
    // row store: one word per byte column, one lane per earlier plane
    //--------------------------------------------------------------------------
    assign w_row_we = r_s1_valid && !r_s1_last;

    always_comb begin
        for (int p = 0; p < LANES; p++) begin
            w_row_wdata[p*8 +: 8] = (PP_W'(p) == r_s1_plane) ? r_s1_data
                                                              : w_row_rdata[p*8 +: 8];
        end
    end

    ibpd_ram #(
        .WIDTH (ROW_DW),
        .DEPTH (ROW_LEN_MAX)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_row_we),
        .i_waddr (r_s1_byte),
        .i_wdata (w_row_wdata),
        .i_re    (w_plane_acc),
        .i_raddr (r_byte_pos),
        .o_rdata (w_row_rdata)
    );

    always_comb begin
        w_s1_word = '0;
        for (int p = 0; p < LANES; p++) begin
            if (PP_W'(p) < r_s1_plane) begin
                w_s1_word[p*8 +: 8] = w_row_rdata[p*8 +: 8];
            end
        end
        for (int p = 0; p < MAX_PLANES; p++) begin
            if (PP_W'(p) == r_s1_plane) begin
                w_s1_word[p*8 +: 8] = r_s1_data;
            end
        end
        for (int i = 0; i < 8; i++) begin
            for (int p = 0; p < MAX_PLANES; p++) begin
                w_s1_codes[i][p] = w_s1_word[p*8 + 7 - i];
            end
        end
    end

    assign w_s1_base = {r_s1_byte, 3'b000};
    assign w_s1_emit = 32'(w_s1_base) < 32'(r_width);
    assign w_s1_adv  = r_s1_valid && (!r_s1_last || w_pb_free);
    assign w_s1_free = !r_s1_valid || w_s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_plane_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_plane_acc) begin
            r_s1_last  <= w_plane_last;
            r_s1_plane <= r_plane_pos;
            r_s1_byte  <= r_byte_pos;
            r_s1_data  <= i_plane_byte;
        end
    end

    //--------------------------------------------------------------------------
    // pixel shifter: one pixel per cycle while the decode stage is free, leftmost first
    //--------------------------------------------------------------------------
    assign w_pb_row_end = (32'(r_pb_col) + 32'd1) == 32'(r_width);
    assign w_pb_last    = (r_pb_col[2:0] == 3'd7) || w_pb_row_end;
    assign w_p_adv      = r_pb_valid && w_d_free;
    assign w_pb_free    = !r_pb_valid || (w_p_adv && w_pb_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pb_valid <= 1'b0;
        end else if (w_s1_adv && r_s1_last && w_s1_emit) begin
            r_pb_valid <= 1'b1;
        end else if (w_p_adv && w_pb_last) begin
            r_pb_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && r_s1_last) begin
            r_pb_codes <= w_s1_codes;
            r_pb_col   <= w_s1_base;
        end else if (w_p_adv) begin
            for (int i = 0; i < 7; i++) begin
                r_pb_codes[i] <= r_pb_codes[i+1];
            end
            r_pb_codes[7] <= '0;
            r_pb_col      <= r_pb_col + COL_W'(1);
        end
    end

    //--------------------------------------------------------------------------
    // palette store
    //--------------------------------------------------------------------------
    assign w_pal_we = w_pal_acc && (32'(i_entry_index) < PALETTE_DEPTH);

    ibpd_ram #(
        .WIDTH (PAL_DW),
        .DEPTH (PALETTE_DEPTH)
    ) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (w_pal_we),
        .i_waddr (i_entry_index[PAL_AW-1:0]),
        .i_wdata ({i_entry_red, i_entry_green, i_entry_blue}),
        .i_re    (w_p_adv),
        .i_raddr (r_pb_codes[0][PAL_AW-1:0]),
        .o_rdata (w_pal_rdata)
    );

    //--------------------------------------------------------------------------
    // decode stage
    //--------------------------------------------------------------------------
    assign w_d_adv  = r_d_valid && (!r_out_valid || i_out_ready);
    assign w_d_free = !r_d_valid || w_d_adv;
    assign w_code   = CODE_W'(r_d_code);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (w_p_adv) begin
            r_d_valid <= 1'b1;
        end else if (w_d_adv) begin
            r_d_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p_adv) begin
            r_d_code    <= r_pb_codes[0];
            r_d_col     <= r_pb_col;
            r_d_row_end <= w_pb_row_end;
        end
    end

    always_comb begin
        w_status     = ST_INDEXED;
        w_red        = '0;
        w_green      = '0;
        w_blue       = '0;
        n_held_red   = r_held_red;
        n_held_green = r_held_green;
        n_held_blue  = r_held_blue;
        if (r_ham) begin
            if (w_code[CODE_W-1:6] != '0) begin
                w_status = ST_BAD_HAM;
            end else begin
                w_status = ST_RGB;
                unique case (w_code[5:4])
                    HAM_SET: begin
                        if (32'(w_code) >= 32'(r_pal)) begin
                            w_status = ST_RANGE;
                        end else begin
                            n_held_red   = w_pal_rdata[2*COLOR_W +: COLOR_W];
                            n_held_green = w_pal_rdata[COLOR_W +: COLOR_W];
                            n_held_blue  = w_pal_rdata[0 +: COLOR_W];
                        end
                    end
                    HAM_BLUE:  n_held_blue  = widen_nibble(w_code[3:0]);
                    HAM_RED:   n_held_red   = widen_nibble(w_code[3:0]);
                    HAM_GREEN: n_held_green = widen_nibble(w_code[3:0]);
                endcase
                if (w_status == ST_RGB) begin
                    w_red   = n_held_red;
                    w_green = n_held_green;
                    w_blue  = n_held_blue;
                end
            end
        end else if (32'(r_planes) == RGB_PLANES) begin
            w_status = ST_RGB;
            w_red    = w_code[2*COLOR_W +: COLOR_W];
            w_green  = w_code[COLOR_W +: COLOR_W];
            w_blue   = w_code[0 +: COLOR_W];
        end else if (32'(w_code) >= 32'(r_pal)) begin
            w_status = ST_RANGE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_red   <= '0;
            r_held_green <= '0;
            r_held_blue  <= '0;
        end else if (w_pal_acc && (i_entry_index == '0)) begin
            r_held_red   <= i_entry_red;
            r_held_green <= i_entry_green;
            r_held_blue  <= i_entry_blue;
        end else if (w_d_adv) begin
            r_held_red   <= n_held_red;
            r_held_green <= n_held_green;
            r_held_blue  <= n_held_blue;
        end
    end

    //--------------------------------------------------------------------------
    // output register
    //--------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_d_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_d_adv) begin
            r_out_status  <= w_status;
            r_out_code    <= w_code;
            r_out_red     <= w_red;
            r_out_green   <= w_green;
            r_out_blue    <= w_blue;
            r_out_column  <= COLUMN_W'(r_d_col);
            r_out_row_end <= r_d_row_end;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_pixel_code = r_out_code;
    assign o_red        = r_out_red;
    assign o_green      = r_out_green;
    assign o_blue       = r_out_blue;
    assign o_column     = r_out_column;
    assign o_row_end    = r_out_row_end;

    //--------------------------------------------------------------------------
    // registers
    //--------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WD_W'(1);
            r_planes    <= NP_W'(1);
            r_ham       <= 1'b0;
            r_pal       <= '0;
            r_plane_pos <= '0;
            r_byte_pos  <= '0;
        end else begin
            r_width     <= n_width;
            r_planes    <= n_planes;
            r_ham       <= n_ham;
            r_pal       <= n_pal;
            r_plane_pos <= n_plane_pos;
            r_byte_pos  <= n_byte_pos;
        end
    end

    //--------------------------------------------------------------------------
    // assertions
    //--------------------------------------------------------------------------
    `IBPD_ASSERT_IMPL(a_pal_write_drained, w_pal_acc, !r_s1_valid && !r_pb_valid && !r_d_valid)
    `IBPD_ASSERT_IMPL(a_row_rmw_no_alias, w_plane_acc && w_row_we, r_byte_pos != r_s1_byte)
    `IBPD_ASSERT_IMPL(a_pixel_in_row, r_pb_valid, 32'(r_pb_col) < 32'(r_width))
    `IBPD_ASSERT_NEXT(a_entry0_loads_held, w_pal_acc && (i_entry_index == '0), r_held_red == $past(i_entry_red))

endmodule

`default_nettype wire
